// File: src/fat_chain_manager_unit_defines.svh
// Assertion macros for the FAT chain manager.
`ifndef FAT_CHAIN_MANAGER_UNIT_DEFINES_SVH
`define FAT_CHAIN_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define FCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define FCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fcm_pkg.sv
// Shared types, codes and constants of the FAT chain manager.
package fcm_pkg;

    localparam int ENTRIES_PER_FAT_BLOCK = 2048;
    localparam int TABLE_DEPTH           = 8192;

    localparam logic [15:0] CHAIN_END = 16'hFFFF;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_WALK   = 3'd2;
    localparam logic [2:0] OP_ALLOC  = 3'd3;
    localparam logic [2:0] OP_EXTEND = 3'd4;
    localparam logic [2:0] OP_FREE   = 3'd5;
    localparam logic [2:0] OP_COUNT  = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic CFG_FAT_BLOCKS  = 1'b0;
    localparam logic CFG_DATA_BLOCKS = 1'b1;

    localparam logic [2:0]  FAT_BLOCKS_RESET  = 3'd4;
    localparam logic [13:0] DATA_BLOCKS_RESET = 14'd8192;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] index;
        logic [12:0] hop_count;
        logic [15:0] entry_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_value;
    } out_word_t;

    typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_CUR, RD_SCAN} rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_CLEAR, WR_IDX_VAL, WR_FOUND_END, WR_IDX_FOUND, WR_CUR_ZERO
    } wr_sel_t;

    typedef enum logic [1:0] {CUR_HOLD, CUR_RDATA, CUR_FOUND} cur_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO, RES_RDATA, RES_VAL, RES_CUR, RES_CNT, RES_END
    } res_sel_t;

    typedef struct packed {
        logic       latch_in;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        cur_sel_t   cur_sel;
        logic       fwd;
        logic       hop_dec;
        logic       cnt_inc;
        logic       scan_start;
        logic       scan_count;
        logic       res_load;
        res_sel_t   res_sel;
        logic [1:0] res_status;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       idx_end;
        logic       idx_oor;
        logic       cur_end;
        logic       cur_oor;
        logic       hops_zero;
        logic       rdata_zero;
        logic       rdata_end;
        logic       scan_hit;
        logic       scan_done;
        logic       clr_last;
    } stat_t;

    localparam cmd_t CMD_NOP = '{
        latch_in:   1'b0,
        rd_sel:     RD_NONE,
        wr_sel:     WR_NONE,
        cur_sel:    CUR_HOLD,
        fwd:        1'b0,
        hop_dec:    1'b0,
        cnt_inc:    1'b0,
        scan_start: 1'b0,
        scan_count: 1'b0,
        res_load:   1'b0,
        res_sel:    RES_ZERO,
        res_status: ST_OK,
        out_load:   1'b0
    };

endpackage

// File: src/fat_chain_manager_unit.sv
// Top level of the FAT chain manager: controller, datapath and assertions.
// Each word is latched, dispatched by opcode, worked through the table, and its result
// is loaded into the output register once the previous result has been taken. One word
// is in work at a time. Reset is synchronous active-low, then a clearing pass over
// every table entry with s_ready low; config writes are taken throughout.
`include "fat_chain_manager_unit_defines.svh"

module fat_chain_manager_unit #(
    parameter int ENTRIES_PER_FAT_BLOCK = fcm_pkg::ENTRIES_PER_FAT_BLOCK,
    parameter int TABLE_DEPTH           = fcm_pkg::TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fcm_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fcm_pkg::out_word_t m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [13:0]        cfg_wr_data
);

    fcm_pkg::cmd_t  cmd;
    fcm_pkg::stat_t stat;

    fcm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    fcm_datapath #(
        .ENTRIES_PER_FAT_BLOCK(ENTRIES_PER_FAT_BLOCK),
        .TABLE_DEPTH          (TABLE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .cmd        (cmd),
        .stat       (stat)
    );

    `FCM_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "input still open after accepting a word")
    `FCM_ASSERT_NOW(a_idle_no_write, s_ready, cmd.wr_sel == fcm_pkg::WR_NONE,
        "table written while idle")
    `FCM_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_valid || m_ready,
        "result overwritten before it was taken")
    `FCM_ASSERT_NEXT(a_result_valid, cmd.out_load, m_valid,
        "loaded result not presented")

endmodule

// File: src/fcm_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
module fcm_ram #(
    parameter int DEPTH = fcm_pkg::TABLE_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data
);

    logic [15:0] table_mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/fcm_datapath.sv
// Datapath: config registers, working registers, scan engine, table and result registers.
module fcm_datapath #(
    parameter int ENTRIES_PER_FAT_BLOCK = fcm_pkg::ENTRIES_PER_FAT_BLOCK,
    parameter int TABLE_DEPTH           = fcm_pkg::TABLE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fcm_pkg::in_word_t s_data,
    output fcm_pkg::out_word_t m_data,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [13:0]       cfg_wr_data,
    input  fcm_pkg::cmd_t     cmd,
    output fcm_pkg::stat_t    stat
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = 17;

    logic [2:0]  fbc_reg, fbc_next;
    logic [13:0] dbc_reg, dbc_next;

    logic [2:0]  op_reg, op_next;
    logic [15:0] idx_reg, idx_next;
    logic [12:0] hops_reg, hops_next;
    logic [15:0] val_reg, val_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] cnt_reg, cnt_next;

    logic [RW-1:0] scan_addr_reg, scan_addr_next;
    logic [RW-1:0] scan_lim_reg, scan_lim_next;
    logic          scan_valid_reg, scan_valid_next;
    logic [15:0]   scan_tag_reg, scan_tag_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_value_reg, res_value_next;
    fcm_pkg::out_word_t out_reg, out_next;

    logic [RW-1:0] prod_w, range_w, lim_w;
    logic [15:0]   cur_now, rd_data;
    logic          scan_issue;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   wr_data;

    // active range and count limit, both capped at the table depth
    assign prod_w  = RW'(fbc_reg) * RW'(ENTRIES_PER_FAT_BLOCK);
    assign range_w = (prod_w > RW'(TABLE_DEPTH)) ? RW'(TABLE_DEPTH) : prod_w;
    assign lim_w   = (RW'(dbc_reg) > RW'(TABLE_DEPTH)) ? RW'(TABLE_DEPTH) : RW'(dbc_reg);

    assign cur_now    = cmd.fwd ? rd_data : cur_reg;
    assign scan_issue = (cmd.rd_sel == fcm_pkg::RD_SCAN) && (scan_addr_reg < scan_lim_reg);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        case (cmd.rd_sel)
            fcm_pkg::RD_IDX: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            fcm_pkg::RD_CUR: begin
                rd_en   = 1'b1;
                rd_addr = cur_now[AW-1:0];
            end
            fcm_pkg::RD_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = scan_addr_reg[AW-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cur_reg[AW-1:0];
        wr_data = 16'd0;
        case (cmd.wr_sel)
            fcm_pkg::WR_CLEAR: begin
                wr_addr = clr_addr_reg;
            end
            fcm_pkg::WR_IDX_VAL: begin
                wr_addr = idx_reg[AW-1:0];
                wr_data = val_reg;
            end
            fcm_pkg::WR_FOUND_END: begin
                wr_data = fcm_pkg::CHAIN_END;
            end
            fcm_pkg::WR_IDX_FOUND: begin
                wr_addr = idx_reg[AW-1:0];
                wr_data = cur_reg;
            end
            fcm_pkg::WR_CUR_ZERO: begin
                wr_data = 16'd0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    fcm_ram #(
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    always_comb begin
        fbc_next = fbc_reg;
        dbc_next = dbc_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fcm_pkg::CFG_FAT_BLOCKS:  fbc_next = cfg_wr_data[2:0];
                fcm_pkg::CFG_DATA_BLOCKS: dbc_next = cfg_wr_data;
                default: begin
                    fbc_next = fbc_reg;
                end
            endcase
        end
    end

    always_comb begin
        op_next   = op_reg;
        idx_next  = idx_reg;
        hops_next = hops_reg;
        val_next  = val_reg;
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        if (cmd.latch_in) begin
            op_next   = s_data.opcode;
            idx_next  = s_data.index;
            hops_next = s_data.hop_count;
            val_next  = s_data.entry_value;
            cur_next  = s_data.index;
            cnt_next  = 16'd0;
        end else begin
            case (cmd.cur_sel)
                fcm_pkg::CUR_RDATA: cur_next = rd_data;
                fcm_pkg::CUR_FOUND: cur_next = scan_tag_reg;
                default:            cur_next = cur_reg;
            endcase
            if (cmd.hop_dec) begin
                hops_next = hops_reg - 13'd1;
            end
            if (cmd.cnt_inc) begin
                cnt_next = cnt_reg + 16'd1;
            end
        end
    end

    always_comb begin
        scan_addr_next  = scan_addr_reg;
        scan_lim_next   = scan_lim_reg;
        scan_tag_next   = scan_tag_reg;
        scan_valid_next = 1'b0;
        if (cmd.scan_start) begin
            // free search starts at entry 1, the count at entry 0
            scan_addr_next = cmd.scan_count ? RW'(0) : RW'(1);
            scan_lim_next  = cmd.scan_count ? lim_w : range_w;
        end else if (scan_issue) begin
            scan_addr_next  = scan_addr_reg + RW'(1);
            scan_valid_next = 1'b1;
            scan_tag_next   = scan_addr_reg[15:0];
        end
    end

    always_comb begin
        clr_addr_next = clr_addr_reg;
        if (cmd.wr_sel == fcm_pkg::WR_CLEAR) begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end
    end

    always_comb begin
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_next        = out_reg;
        if (cmd.res_load) begin
            res_status_next = cmd.res_status;
            case (cmd.res_sel)
                fcm_pkg::RES_RDATA: res_value_next = rd_data;
                fcm_pkg::RES_VAL:   res_value_next = val_reg;
                fcm_pkg::RES_CUR:   res_value_next = cur_now;
                fcm_pkg::RES_CNT:   res_value_next = cnt_reg;
                fcm_pkg::RES_END:   res_value_next = fcm_pkg::CHAIN_END;
                default:            res_value_next = 16'd0;
            endcase
        end
        if (cmd.out_load) begin
            out_next.status       = res_status_reg;
            out_next.result_value = res_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fbc_reg        <= fcm_pkg::FAT_BLOCKS_RESET;
            dbc_reg        <= fcm_pkg::DATA_BLOCKS_RESET;
            scan_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
        end else begin
            fbc_reg        <= fbc_next;
            dbc_reg        <= dbc_next;
            scan_valid_reg <= scan_valid_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        hops_reg       <= hops_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        scan_addr_reg  <= scan_addr_next;
        scan_lim_reg   <= scan_lim_next;
        scan_tag_reg   <= scan_tag_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_reg        <= out_next;
    end

    assign m_data = out_reg;

    assign stat.op         = op_reg;
    assign stat.idx_end    = (idx_reg == fcm_pkg::CHAIN_END);
    assign stat.idx_oor    = ({1'b0, idx_reg} >= range_w);
    assign stat.cur_end    = (cur_now == fcm_pkg::CHAIN_END);
    assign stat.cur_oor    = ({1'b0, cur_now} >= range_w);
    assign stat.hops_zero  = (hops_reg == 13'd0);
    assign stat.rdata_zero = (rd_data == 16'd0);
    assign stat.rdata_end  = (rd_data == fcm_pkg::CHAIN_END);
    assign stat.scan_hit   = scan_valid_reg && (rd_data == 16'd0);
    assign stat.scan_done  = !scan_valid_reg && (scan_addr_reg >= scan_lim_reg);
    assign stat.clr_last   = (clr_addr_reg == AW'(TABLE_DEPTH - 1));

endmodule

// File: src/fcm_ctrl.sv
// Controller state machine: sequences each opcode and the result handshake.
module fcm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  fcm_pkg::stat_t stat,
    output fcm_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_READ_DATA, S_WALK, S_WALK_NEXT, S_EXT_DATA,
        S_SEARCH, S_LINK, S_LINK2, S_FREE_CHECK, S_FREE_DATA, S_COUNT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = fcm_pkg::CMD_NOP;
        case (state_reg)
            S_CLEAR: begin
                cmd.wr_sel = fcm_pkg::WR_CLEAR;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_DONE;
                case (stat.op)
                    fcm_pkg::OP_READ: begin
                        if (stat.idx_oor) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = fcm_pkg::ST_RANGE;
                        end else begin
                            cmd.rd_sel = fcm_pkg::RD_IDX;
                            state_next = S_READ_DATA;
                        end
                    end
                    fcm_pkg::OP_WRITE: begin
                        cmd.res_load = 1'b1;
                        if (stat.idx_oor) begin
                            cmd.res_status = fcm_pkg::ST_RANGE;
                        end else begin
                            cmd.wr_sel  = fcm_pkg::WR_IDX_VAL;
                            cmd.res_sel = fcm_pkg::RES_VAL;
                        end
                    end
                    fcm_pkg::OP_WALK: begin
                        state_next = S_WALK;
                    end
                    fcm_pkg::OP_ALLOC: begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SEARCH;
                    end
                    fcm_pkg::OP_EXTEND: begin
                        if (stat.idx_end) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SEARCH;
                        end else if (stat.idx_oor) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = fcm_pkg::ST_RANGE;
                        end else begin
                            cmd.rd_sel = fcm_pkg::RD_IDX;
                            state_next = S_EXT_DATA;
                        end
                    end
                    fcm_pkg::OP_FREE: begin
                        state_next = S_FREE_CHECK;
                    end
                    fcm_pkg::OP_COUNT: begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_count = 1'b1;
                        state_next     = S_COUNT;
                    end
                    default: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = fcm_pkg::ST_RANGE;
                    end
                endcase
            end
            S_READ_DATA: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = fcm_pkg::RES_RDATA;
                state_next   = S_DONE;
            end
            S_WALK, S_WALK_NEXT: begin
                // in the follow-up state the link just read is the current block
                if (state_reg == S_WALK_NEXT) begin
                    cmd.fwd     = 1'b1;
                    cmd.cur_sel = fcm_pkg::CUR_RDATA;
                end
                cmd.res_sel = fcm_pkg::RES_CUR;
                if (stat.hops_zero) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else if (stat.cur_end) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fcm_pkg::ST_EARLY_END;
                    state_next     = S_DONE;
                end else if (stat.cur_oor) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fcm_pkg::ST_RANGE;
                    state_next     = S_DONE;
                end else begin
                    cmd.rd_sel  = fcm_pkg::RD_CUR;
                    cmd.hop_dec = 1'b1;
                    state_next  = S_WALK_NEXT;
                end
            end
            S_EXT_DATA: begin
                if (stat.rdata_end) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SEARCH;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = fcm_pkg::RES_RDATA;
                    state_next   = S_DONE;
                end
            end
            S_SEARCH: begin
                cmd.rd_sel = fcm_pkg::RD_SCAN;
                if (stat.scan_hit) begin
                    cmd.cur_sel = fcm_pkg::CUR_FOUND;
                    state_next  = S_LINK;
                end else if (stat.scan_done) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_sel    = fcm_pkg::RES_END;
                    cmd.res_status = fcm_pkg::ST_FULL;
                    state_next     = S_DONE;
                end
            end
            S_LINK: begin
                cmd.wr_sel  = fcm_pkg::WR_FOUND_END;
                cmd.res_sel = fcm_pkg::RES_CUR;
                if ((stat.op == fcm_pkg::OP_EXTEND) && !stat.idx_end) begin
                    state_next = S_LINK2;
                end else begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_LINK2: begin
                cmd.wr_sel   = fcm_pkg::WR_IDX_FOUND;
                cmd.res_load = 1'b1;
                cmd.res_sel  = fcm_pkg::RES_CUR;
                state_next   = S_DONE;
            end
            S_FREE_CHECK: begin
                cmd.res_sel = fcm_pkg::RES_CNT;
                if (stat.cur_end) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else if (stat.cur_oor) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fcm_pkg::ST_RANGE;
                    state_next     = S_DONE;
                end else begin
                    cmd.rd_sel = fcm_pkg::RD_CUR;
                    state_next = S_FREE_DATA;
                end
            end
            S_FREE_DATA: begin
                if (stat.rdata_zero) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_sel    = fcm_pkg::RES_CNT;
                    cmd.res_status = fcm_pkg::ST_EARLY_END;
                    state_next     = S_DONE;
                end else begin
                    cmd.wr_sel  = fcm_pkg::WR_CUR_ZERO;
                    cmd.cnt_inc = 1'b1;
                    cmd.cur_sel = fcm_pkg::CUR_RDATA;
                    state_next  = S_FREE_CHECK;
                end
            end
            S_COUNT: begin
                cmd.rd_sel  = fcm_pkg::RD_SCAN;
                cmd.cnt_inc = stat.scan_hit;
                if (stat.scan_done) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = fcm_pkg::RES_CNT;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: dv/fcm_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the FAT chain manager: table predictor and result check.
package fcm_scoreboard_pkg;
    import fcm_pkg::*;

    class fat_chain_scoreboard;
        logic [15:0] fat_image [TABLE_DEPTH];
        int unsigned fat_blocks;
        int unsigned data_blocks;
        out_word_t   awaited[$];
        int unsigned mismatches;
        int unsigned replies_seen;

        function new();
            foreach (fat_image[i]) fat_image[i] = '0;
            fat_blocks   = FAT_BLOCKS_RESET;
            data_blocks  = DATA_BLOCKS_RESET;
            mismatches   = 0;
            replies_seen = 0;
        endfunction

        function void set_geometry(int unsigned fat_cnt, int unsigned data_cnt);
            fat_blocks  = fat_cnt;
            data_blocks = data_cnt;
        endfunction

        function int unsigned span();
            int unsigned n;
            n = fat_blocks * ENTRIES_PER_FAT_BLOCK;
            return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
        endfunction

        // lowest free entry above 0 becomes a chain end; returns lim when full
        function int unsigned claim_free(int unsigned lim, inout out_word_t reply);
            for (int unsigned i = 1; i < lim; i++) begin
                if (fat_image[i] == 16'h0000) begin
                    fat_image[i] = CHAIN_END;
                    reply.result_value = 16'(i);
                    return i;
                end
            end
            reply.status = ST_FULL;
            reply.result_value = CHAIN_END;
            return lim;
        endfunction

        function out_word_t predict_reply(in_word_t w);
            out_word_t   reply;
            int unsigned lim;
            int unsigned cur;
            int unsigned nxt;
            int unsigned tally;
            int unsigned fresh;
            reply.status = ST_OK;
            reply.result_value = '0;
            lim = span();
            tally = 0;
            case (w.opcode)
                OP_READ: begin
                    if (w.index >= lim) reply.status = ST_RANGE;
                    else reply.result_value = fat_image[w.index];
                end
                OP_WRITE: begin
                    if (w.index >= lim) begin
                        reply.status = ST_RANGE;
                    end else begin
                        fat_image[w.index] = w.entry_value;
                        reply.result_value = w.entry_value;
                    end
                end
                OP_WALK: begin
                    cur = w.index;
                    for (int unsigned i = 0; i < w.hop_count; i++) begin
                        if (cur == CHAIN_END) begin
                            reply.status = ST_EARLY_END;
                            break;
                        end
                        if (cur >= lim) begin
                            reply.status = ST_RANGE;
                            break;
                        end
                        cur = fat_image[cur];
                    end
                    reply.result_value = 16'(cur);
                end
                OP_ALLOC: begin
                    fresh = claim_free(lim, reply);
                end
                OP_EXTEND: begin
                    if (w.index == CHAIN_END) begin
                        fresh = claim_free(lim, reply);
                    end else if (w.index >= lim) begin
                        reply.status = ST_RANGE;
                    end else if (fat_image[w.index] != CHAIN_END) begin
                        reply.result_value = fat_image[w.index];
                    end else begin
                        fresh = claim_free(lim, reply);
                        if (fresh < lim) fat_image[w.index] = 16'(fresh);
                    end
                end
                OP_FREE: begin
                    cur = w.index;
                    while (cur != CHAIN_END) begin
                        if (cur >= lim) begin
                            reply.status = ST_RANGE;
                            break;
                        end
                        nxt = fat_image[cur];
                        if (nxt == 0) begin
                            reply.status = ST_EARLY_END;
                            break;
                        end
                        fat_image[cur] = '0;
                        tally++;
                        cur = nxt;
                    end
                    reply.result_value = 16'(tally);
                end
                OP_COUNT: begin
                    for (int unsigned i = 0; i < data_blocks && i < TABLE_DEPTH; i++) begin
                        if (fat_image[i] == 16'h0000) tally++;
                    end
                    reply.result_value = 16'(tally);
                end
                default: begin
                    reply.status = ST_RANGE;
                end
            endcase
            return reply;
        endfunction

        function out_word_t note_request(in_word_t w);
            out_word_t reply;
            reply = predict_reply(w);
            awaited.push_back(reply);
            return reply;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void flag(string what, out_word_t want, out_word_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected status %0d value 0x%04h, got status %0d value 0x%04h",
                         $time, what, want.status, want.result_value,
                         got.status, got.result_value);
            end
        endfunction

        function void check_reply(out_word_t got);
            out_word_t want;
            replies_seen++;
            if (awaited.size() == 0) begin
                flag("word with nothing awaited", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.result_value !== want.result_value) begin
                flag("result mismatch", want, got);
            end
        endfunction
    endclass

endpackage

// File: dv/fat_chain_manager_unit_test.sv
`timescale 1ns / 100ps
// Top of the FAT chain manager testbench: clock, reset, drivers and phases.
module fat_chain_manager_unit_test;
    import fcm_pkg::*;
    import fcm_scoreboard_pkg::*;

    localparam logic [2:0]  OP_UNUSED    = 3'd7;
    // worst item: a full-table free or count plus the longest stall and gap, many times over
    localparam int unsigned LIMIT_CYCLES = 100_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_HEADS    = 64;
    localparam int unsigned IMAGE_ENTRIES = 256;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_word_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_word_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [13:0] cfg_wr_data = '0;

    fat_chain_scoreboard sb = new();
    out_word_t   last_reply;
    int unsigned span_now;
    logic [15:0] cursor;
    logic [15:0] chain_heads[$];
    bit          quiet;
    int unsigned cycle_count = 0;

    fat_chain_manager_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_reply(m_data);
    end

    // result side: random stalls, one long hold-off early on
    initial begin
        bit          pressed;
        int unsigned pick;
        int unsigned stretch;
        logic        level;
        pressed = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!pressed && sb.replies_seen >= 40) begin
                pressed = 1'b1;
                level   = 1'b0;
                stretch = 400;
            end else if (quiet) begin
                level   = 1'b1;
                stretch = 1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    level   = 1'b1;
                    stretch = $urandom_range(1, 30);
                end else if (pick < 92) begin
                    level   = 1'b0;
                    stretch = $urandom_range(1, 3);
                end else begin
                    level   = 1'b0;
                    stretch = $urandom_range(10, 40);
                end
            end
            m_ready <= level;
            repeat (stretch) @(posedge aclk);
        end
    end

    function automatic in_word_t make_word(logic [2:0] op, logic [15:0] idx,
                                           logic [12:0] hops, logic [15:0] val);
        in_word_t w;
        w.opcode      = op;
        w.index       = idx;
        w.hop_count   = hops;
        w.entry_value = val;
        return w;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60 && chain_heads.size() != 0)
            return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        if (r < 85) return 16'($urandom_range(0, span_now - 1));
        if (r < 92) return CHAIN_END;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(in_word_t w);
        int unsigned gap;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        last_reply = sb.note_request(w);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic program_geometry(int unsigned fat_blocks, int unsigned data_blocks);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_FAT_BLOCKS;
        cfg_wr_data <= 14'(fat_blocks);
        @(posedge aclk);
        cfg_index   <= CFG_DATA_BLOCKS;
        cfg_wr_data <= 14'(data_blocks);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_geometry(fat_blocks, data_blocks);
        span_now = sb.span();
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic note_head(logic [15:0] blk);
        chain_heads.push_back(blk);
        if (chain_heads.size() > MAX_HEADS) void'(chain_heads.pop_front());
    endtask

    task automatic run_directed();
        send_word(make_word(OP_COUNT,  16'd0,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_READ,   16'd0,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_READ,   16'd8191,  13'($urandom), 16'($urandom)));
        send_word(make_word(OP_READ,   16'd8192,  13'($urandom), 16'($urandom)));
        send_word(make_word(OP_WRITE,  CHAIN_END, 13'($urandom), 16'hFFFF));
        send_word(make_word(OP_WRITE,  16'd0,     13'($urandom), 16'hFFFF));
        send_word(make_word(OP_ALLOC,  16'd0,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_EXTEND, 16'd1,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_EXTEND, 16'd1,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_EXTEND, CHAIN_END, 13'($urandom), 16'($urandom)));
        send_word(make_word(OP_WALK,   16'd1,     13'd0,         16'($urandom)));
        send_word(make_word(OP_WALK,   16'd1,     13'd2,         16'($urandom)));
        send_word(make_word(OP_WALK,   16'd1,     13'd8191,      16'($urandom)));
        send_word(make_word(OP_WRITE,  16'd5,     13'($urandom), 16'd9000));
        send_word(make_word(OP_WALK,   16'd5,     13'd1,         16'($urandom)));
        send_word(make_word(OP_WALK,   16'd5,     13'd2,         16'($urandom)));
        send_word(make_word(OP_FREE,   16'd1,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_FREE,   16'd1,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_FREE,   CHAIN_END, 13'($urandom), 16'($urandom)));
        send_word(make_word(OP_FREE,   16'd5,     13'($urandom), 16'($urandom)));
        send_word(make_word(OP_EXTEND, 16'd9000,  13'($urandom), 16'($urandom)));
        send_word(make_word(OP_WRITE,  16'd8191,  13'($urandom), 16'h0000));
        send_word(make_word(OP_UNUSED, 16'h5555,  13'($urandom), 16'($urandom)));
        send_word(make_word(OP_COUNT,  16'd0,     13'($urandom), 16'($urandom)));
    endtask

    // mostly file-like traffic: allocate, append through a cursor, walk and free chains
    task automatic run_random(int unsigned count);
        in_word_t    w;
        int unsigned r;
        int unsigned k;
        repeat (count) begin
            w.opcode      = OP_READ;
            w.index       = pick_index();
            w.hop_count   = 13'($urandom);
            w.entry_value = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                w.opcode = OP_ALLOC;
            end else if (r < 40) begin
                w.opcode = OP_EXTEND;
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 0 || chain_heads.size() == 0) cursor = CHAIN_END;
                    else cursor = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
                end
                w.index = cursor;
            end else if (r < 55) begin
                w.opcode = OP_WALK;
                if ($urandom_range(0, 99) < 85) w.hop_count = 13'($urandom_range(0, 12));
            end else if (r < 65) begin
                w.opcode = OP_FREE;
                if (chain_heads.size() != 0 && $urandom_range(0, 9) < 7) begin
                    k = $urandom_range(0, chain_heads.size() - 1);
                    w.index = chain_heads[k];
                    chain_heads.delete(k);
                end
            end else if (r >= 80 && r < 92) begin
                w.opcode = OP_WRITE;
                case ($urandom_range(0, 3))
                    0: w.entry_value = 16'h0000;
                    1: w.entry_value = CHAIN_END;
                    2: w.entry_value = 16'($urandom_range(1, span_now - 1));
                    default: ;
                endcase
            end else if (r >= 92 && r < 96) begin
                w.opcode = OP_COUNT;
            end else if (r == 96) begin
                w.opcode = OP_UNUSED;
            end
            send_word(w);
            if (w.opcode == OP_EXTEND)
                cursor = (last_reply.status == ST_OK) ? last_reply.result_value : CHAIN_END;
            if (last_reply.status == ST_OK &&
                (w.opcode == OP_ALLOC || (w.opcode == OP_EXTEND && w.index == CHAIN_END)))
                note_head(last_reply.result_value);
        end
    endtask

    // mount-style table load: short chains over the low entries, entry 0 left alone
    task automatic load_image();
        logic [15:0] link;
        for (int unsigned i = 1; i < IMAGE_ENTRIES; i++) begin
            link = (i % 16 == 0 || i == IMAGE_ENTRIES - 1) ? CHAIN_END : 16'(i + 1);
            send_word(make_word(OP_WRITE, 16'(i), 13'($urandom), link));
            if (i % 16 == 1) note_head(16'(i));
        end
    endtask

    initial begin
        cursor = CHAIN_END;
        quiet  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        program_geometry(4, 8192);
        run_directed();
        settle();

        program_geometry(4, 8192);
        run_random(150);
        settle();

        program_geometry(2, 0);
        run_random(120);
        settle();

        quiet = 1'b1;
        program_geometry(3, 100);
        run_random(120);
        settle();
        quiet = 1'b0;

        program_geometry(1, 2048);
        run_random(150);
        settle();

        program_geometry(1, 8192);
        load_image();
        run_random(60);
        settle();

        repeat (64) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
